// ----- rtl/pmlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// pmlpm_pkg
// shared types, name tables and per-byte step functions of the path matchers
// ----------------------------------------------------------------------------
package pmlpm_pkg;

  localparam int DEF_MAX_PATH = 4096;
  localparam int NAME_COUNT   = 9;
  localparam int POS_W        = 4;
  localparam logic [POS_W-1:0] POS_LIMIT = 4'd15;
  localparam int PROC_LEN     = 6;

  // name order: root cwd exe fd fdinfo map_files task self thread-self
  localparam logic [NAME_COUNT-1:0] MAGIC_BITS = 9'h03F;
  localparam logic [NAME_COUNT-1:0] TASK_BIT   = 9'h040;
  localparam logic [NAME_COUNT-1:0] SELF_BITS  = 9'h180;

  localparam logic [95:0] NAME_STR [NAME_COUNT] = '{
    96'("root"), 96'("cwd"), 96'("exe"), 96'("fd"), 96'("fdinfo"),
    96'({"map_", "files"}), 96'("task"), 96'("self"), 96'("thread-self")
  };
  localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
    4'd4, 4'd3, 4'd3, 4'd2, 4'd6, 4'd9, 4'd4, 4'd4, 4'd11
  };
  localparam logic [47:0] PROC_STR = "/proc/";
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [6:0] {
    PH_LIT   = 7'b0000001,
    PH_PID   = 7'b0000010,
    PH_TAIL1 = 7'b0000100,
    PH_TID   = 7'b0001000,
    PH_TAIL2 = 7'b0010000,
    PH_YES   = 7'b0100000,
    PH_NO    = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [POS_W-1:0]      pos;
    logic [NAME_COUNT-1:0] mask;
    logic                  digits;
  } match_t;

  typedef struct packed {
    logic advance;  // the held beat steps the matchers this cycle
    logic last;     // the held beat ends its path
  } stage_ctl_t;

  // character of a name at a position, only called with pos below the length
  function automatic logic [7:0] name_char(input int idx, input logic [POS_W-1:0] pos);
    int sh;
    sh = int'(NAME_LEN[idx]) - 1 - int'(pos);
    if (sh < 0) return 8'h00;
    return NAME_STR[idx][sh*8 +: 8];
  endfunction

  function automatic logic [7:0] proc_char(input logic [POS_W-1:0] pos);
    int sh;
    sh = PROC_LEN - 1 - int'(pos);
    if (sh < 0) return 8'h00;
    return PROC_STR[sh*8 +: 8];
  endfunction

  function automatic match_t comp_begin(input phase_t ph, input logic [NAME_COUNT-1:0] mask);
    match_t r;
    r.phase  = ph;
    r.pos    = '0;
    r.mask   = mask;
    r.digits = 1'b1;
    return r;
  endfunction

  function automatic match_t start_state(input phase_t ph);
    match_t r;
    case (ph)
      PH_PID:   r = comp_begin(PH_PID, SELF_BITS);
      PH_TAIL1: r = comp_begin(PH_TAIL1, MAGIC_BITS | TASK_BIT);
      default:  r = comp_begin(ph, '0);
    endcase
    return r;
  endfunction

  function automatic match_t comp_char(input match_t m, input logic [7:0] c);
    match_t r;
    r = m;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (m.mask[i] && (m.pos >= NAME_LEN[i] || name_char(i, m.pos) != c)) begin
        r.mask[i] = 1'b0;
      end
    end
    if (c < CH_ZERO || c > CH_NINE) r.digits = 1'b0;
    if (m.pos < POS_LIMIT) r.pos = m.pos + 1'b1;
    return r;
  endfunction

  function automatic logic comp_exact(input match_t m, input logic [NAME_COUNT-1:0] bits);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (m.mask[i] && bits[i] && NAME_LEN[i] == m.pos) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic match_t matcher_step(input match_t m, input logic [7:0] c);
    match_t r;
    logic   slash;
    r     = m;
    slash = (c == CH_SLASH);
    case (m.phase)
      PH_LIT: begin
        if (m.pos >= POS_W'(PROC_LEN) || proc_char(m.pos) != c) begin
          r.phase = PH_NO;
        end else if (m.pos == POS_W'(PROC_LEN - 1)) begin
          r = comp_begin(PH_PID, SELF_BITS);
        end else begin
          r.pos = m.pos + 1'b1;
        end
      end
      PH_PID: begin
        if (!slash) r = comp_char(m, c);
        else if (m.pos != '0 && (m.digits || comp_exact(m, SELF_BITS)))
          r = comp_begin(PH_TAIL1, MAGIC_BITS | TASK_BIT);
        else r.phase = PH_NO;
      end
      PH_TAIL1: begin
        if (!slash) r = comp_char(m, c);
        else if (comp_exact(m, MAGIC_BITS)) r.phase = PH_YES;
        else if (comp_exact(m, TASK_BIT)) r = comp_begin(PH_TID, '0);
        else r.phase = PH_NO;
      end
      PH_TID: begin
        if (!slash) r = comp_char(m, c);
        else if (m.pos != '0 && m.digits) r = comp_begin(PH_TAIL2, MAGIC_BITS);
        else r.phase = PH_NO;
      end
      PH_TAIL2: begin
        if (!slash) r = comp_char(m, c);
        else r.phase = comp_exact(m, MAGIC_BITS) ? PH_YES : PH_NO;
      end
      default: r = m;
    endcase
    return r;
  endfunction

  function automatic logic matcher_final(input match_t m);
    logic hit;
    case (m.phase)
      PH_YES:   hit = 1'b1;
      PH_TAIL1: hit = comp_exact(m, MAGIC_BITS);
      PH_TAIL2: hit = comp_exact(m, MAGIC_BITS);
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- rtl/pmlpm_apb.sv -----
// ----------------------------------------------------------------------------
// pmlpm_apb
// register port holding the mode bit
// ----------------------------------------------------------------------------
module pmlpm_apb (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        relative_mode
);
  localparam logic REG_MODE = 1'b0;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      relative_mode <= 1'b0;
    end else if (wr_en) begin
      relative_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, relative_mode} : 32'b0;
endmodule

// ----- rtl/pmlpm_matcher.sv -----
// ----------------------------------------------------------------------------
// pmlpm_matcher
// one component-wise matcher for the proc magic link pattern
// ----------------------------------------------------------------------------
module pmlpm_matcher #(
  parameter pmlpm_pkg::phase_t START = pmlpm_pkg::PH_LIT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pmlpm_pkg::stage_ctl_t ctl,
  input  logic [7:0]            path_byte,
  output logic                  hit
);
  import pmlpm_pkg::*;

  localparam match_t START_STATE = start_state(START);

  match_t state;
  match_t state_next;

  assign state_next = matcher_step(state, path_byte);
  // verdict as if the path ended on this beat
  assign hit = matcher_final(state_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= START_STATE;
    end else if (ctl.advance) begin
      state <= ctl.last ? START_STATE : state_next;
    end
  end
endmodule

// ----- rtl/pmlpm_prefix.sv -----
// ----------------------------------------------------------------------------
// pmlpm_prefix
// detects /proc, /sys or /dev as the whole first component
// ----------------------------------------------------------------------------
module pmlpm_prefix (
  input  logic                  clk,
  input  logic                  rst,
  input  pmlpm_pkg::stage_ctl_t ctl,
  input  logic [7:0]            path_byte,
  output logic                  hit
);
  import pmlpm_pkg::*;

  localparam int PFX_COUNT = 3;
  localparam logic [39:0] PFX_STR [PFX_COUNT] = '{40'("/proc"), 40'("/sys"), 40'("/dev")};
  localparam logic [2:0]  PFX_LEN [PFX_COUNT] = '{3'd5, 3'd4, 3'd4};
  localparam logic [2:0]  POS_MAX = 3'd7;

  logic [2:0]           pos;
  logic [PFX_COUNT-1:0] mask;
  logic                 found;
  logic [2:0]           pos_next;
  logic [PFX_COUNT-1:0] mask_next;
  logic                 found_next;

  always_comb begin
    pos_next   = pos;
    mask_next  = mask;
    found_next = found;
    if (!found) begin
      for (int i = 0; i < PFX_COUNT; i++) begin
        if (mask[i]) begin
          if (pos < PFX_LEN[i]) begin
            if (PFX_STR[i][(int'(PFX_LEN[i]) - 1 - int'(pos))*8 +: 8] != path_byte)
              mask_next[i] = 1'b0;
          end else begin
            if (pos == PFX_LEN[i] && path_byte == CH_SLASH) found_next = 1'b1;
            mask_next[i] = 1'b0;
          end
        end
      end
      if (pos < POS_MAX) pos_next = pos + 1'b1;
    end
  end

  always_comb begin
    hit = found_next;
    for (int i = 0; i < PFX_COUNT; i++) begin
      if (mask_next[i] && PFX_LEN[i] == pos_next) hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.advance && ctl.last)) begin
      pos   <= '0;
      mask  <= '1;
      found <= 1'b0;
    end else if (ctl.advance) begin
      pos   <= pos_next;
      mask  <= mask_next;
      found <= found_next;
    end
  end
endmodule

// ----- rtl/proc_magic_link_path_matcher.sv -----
// ----------------------------------------------------------------------------
// proc_magic_link_path_matcher
// streams a path one byte per beat and flags magic proc links
// ----------------------------------------------------------------------------
// a path enters one byte per beat, its final byte marked by last, and one
// result beat (escapes, is_virtual) leaves for each path once its last byte
// has passed from the input register into the result register. each byte
// passes through the small per-byte matcher logic into the matcher state.
// the block takes a byte every cycle, but a result that waits holds back
// the next last byte in the input register, and with it the whole input.
// relative_mode at register 0 picks absolute checking (0) or checking
// relative to a /proc directory (1); write it only while no path is in
// flight. is_virtual is always 0 in relative mode.
module proc_magic_link_path_matcher #(
  parameter int MAX_PATH = pmlpm_pkg::DEF_MAX_PATH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  path_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        escapes,
  output logic        is_virtual
);
  import pmlpm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATH + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATH);
  localparam logic [LEN_W:0]   PROC_ADD = (LEN_W + 1)'(PROC_LEN);
  localparam logic [LEN_W:0]   LIMIT = (LEN_W + 1)'(MAX_PATH);

  logic             relative_mode;
  // input register
  logic             in_full;
  logic [7:0]       in_byte;
  logic             in_last;
  stage_ctl_t       ctl;
  // matcher verdicts for the held byte
  logic             abs_hit;
  logic             direct_hit;
  logic             task_hit;
  logic             prefix_hit;
  // path length, saturating at MAX_PATH
  logic [LEN_W-1:0] path_length;
  logic [LEN_W-1:0] path_length_next;
  logic             room_for_proc;
  logic             rel_esc;

  pmlpm_apb u_apb (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .relative_mode
  );

  // the held byte moves on unless it ends a path and the result slot is busy
  assign ctl.last    = in_last;
  assign ctl.advance = in_full && (!in_last || !out_valid || out_ready);
  assign in_ready    = !in_full || ctl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= path_byte;
      in_last <= last;
    end
  end

  // absolute pattern, and the relative one with /proc/ already consumed
  pmlpm_matcher #(.START(PH_LIT)) u_abs (
    .clk, .rst, .ctl, .path_byte(in_byte), .hit(abs_hit)
  );
  pmlpm_matcher #(.START(PH_PID)) u_direct (
    .clk, .rst, .ctl, .path_byte(in_byte), .hit(direct_hit)
  );
  // bare magic name or task/<tid>/magic
  pmlpm_matcher #(.START(PH_TAIL1)) u_task (
    .clk, .rst, .ctl, .path_byte(in_byte), .hit(task_hit)
  );
  pmlpm_prefix u_prefix (
    .clk, .rst, .ctl, .path_byte(in_byte), .hit(prefix_hit)
  );

  assign path_length_next = (path_length == LEN_MAX) ? path_length : path_length + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_length <= '0;
    end else if (ctl.advance) begin
      path_length <= in_last ? '0 : path_length_next;
    end
  end

  // the prepended /proc/ must still fit below MAX_PATH
  assign room_for_proc = ({1'b0, path_length_next} + PROC_ADD) < LIMIT;
  assign rel_esc       = (room_for_proc && direct_hit) || task_hit;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance && in_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && in_last) begin
      escapes    <= relative_mode ? rel_esc : abs_hit;
      is_virtual <= !relative_mode && prefix_hit && !abs_hit;
    end
  end
endmodule

// ----- rtl/pmlpm_checker.sv -----
// ----------------------------------------------------------------------------
// pmlpm_checker
// port-level checks on flow and result consistency of the path matcher
// ----------------------------------------------------------------------------
module pmlpm_checker (
  input logic clk,
  input logic rst,
  input logic pready,
  input logic in_valid,
  input logic in_ready,
  input logic last,
  input logic out_valid,
  input logic out_ready,
  input logic escapes,
  input logic is_virtual
);
  // a waiting result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(escapes) && $stable(is_virtual))
    else $error("result beat dropped or changed while stalled");

  // a path cannot be both escaping and merely virtual
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(escapes && is_virtual))
    else $error("escapes and is_virtual both set");

  // with no result pending the input side never stalls
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // a byte that does not end its path never blocks the next one
  a_mid_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last |=> in_ready)
    else $error("input stalled behind a mid-path byte");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("register port not ready");
endmodule

bind proc_magic_link_path_matcher pmlpm_checker u_chk (.*);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the magic proc link path matcher
// ----------------------------------------------------------------------------
// paths stream in one byte per beat over valid/ready and the verdict beat
// for each path is checked, field by field, against a string-level model of
// the escape and virtual-prefix rules. a short table of hand-picked paths
// runs first (typed verdicts where they are obvious), then rounds of random
// link-shaped paths, prefixes and noise, alternating absolute and relative
// mode, with random idle and stall bursts on both sides except in the final
// round.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic esc;
    logic virt;
  } verdict_t;

  // walk over the components that follow /proc/ (or a relative start)
  typedef enum logic [2:0] {
    WALK_PID,
    WALK_NAME,
    WALK_TID,
    WALK_NAME2,
    WALK_HIT,
    WALK_MISS
  } link_walk_t;

  // one row of the directed table: mode, text, filler count, typed verdict
  typedef struct {
    bit    rel;
    string txt;
    int    pad;
    bit    known;
    bit    esc;
    bit    virt;
  } path_row_t;

  localparam int         PATH_MAX           = pmlpm_pkg::DEF_MAX_PATH;
  localparam logic [2:0] ADDR_RELATIVE_MODE = 3'd0;
  localparam char_t      SLASH              = 8'h2F;
  localparam int         ROWS               = 26;
  localparam int         RANDOM_BYTES       = 800;
  localparam int         RANDOM_ROUNDS      = 8;
  localparam int         SETTLE_CYCLES      = 4;
  localparam int         MAX_SHOWN          = 10;
  localparam string      MAP_NAME           = {"map_", "files"};

  logic        clk;
  logic        rst        = 1'b1;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  path_byte  = 8'h2F;
  logic        last       = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        escapes;
  logic        is_virtual;

  verdict_t path_verdicts[$];   // verdicts of paths taken in, oldest first
  char_t    gen_q[$];           // path being built for the next send
  bit       rel_mode_shadow = 1'b0;
  int       mismatches      = 0;
  int       in_gap_pct      = 0;
  int       out_gap_pct     = 0;
  int       stall_left      = 0;

  string magic_names[6] = '{"root", "cwd", "exe", "fd", "fdinfo", MAP_NAME};

  // first six are the magic names, then the other known names, then near misses
  string name_pool[16] = '{
    "root", "cwd", "exe", "fd", "fdinfo", MAP_NAME, "task", "self",
    "thread-self", "roo", "cwdx", "fdinf", "map_file", "tasks", "x", "fd0"
  };

  string prefix_pool[6] = '{"/proc", "/sys", "/dev", "/pro", "/sysx", "/de"};

  // directed paths: whole components, their near misses, both modes, and a
  // couple of padded paths
  path_row_t path_table [ROWS] = '{
    '{1'b0, "/",                        0,    1'b1, 1'b0, 1'b0},
    '{1'b0, "/proc",                    0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/proc/",                   0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/sys/x",                   0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/dev",                     0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/devx",                    0,    1'b1, 1'b0, 1'b0},
    '{1'b0, "/proc/self/root",          0,    1'b1, 1'b1, 1'b0},
    '{1'b0, "/proc/thread-self/cwd/",   0,    1'b1, 1'b1, 1'b0},
    '{1'b0, "/proc/1234/task/77/exe",   0,    1'b1, 1'b1, 1'b0},
    '{1'b0, "/proc/42/task/9/fdinfo/3", 0,    1'b1, 1'b1, 1'b0},
    '{1'b0, {"/proc/self/", MAP_NAME},  0,    1'b1, 1'b1, 1'b0},
    '{1'b0, "/proc/self/task",          0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/proc/selfx/fd",           0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/proc/12a/fd",             0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/proc/self/fdx",           0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "/proc/1/task//fd",         0,    1'b1, 1'b0, 1'b1},
    '{1'b0, "\001\377",                 0,    1'b1, 1'b0, 1'b0},
    '{1'b1, "fd",                       0,    1'b1, 1'b1, 1'b0},
    '{1'b1, "root/",                    0,    1'b1, 1'b1, 1'b0},
    '{1'b1, "task/5/cwd",               0,    1'b1, 1'b1, 1'b0},
    '{1'b1, "self/exe",                 0,    1'b1, 1'b1, 1'b0},
    '{1'b1, {"123/task/4/", MAP_NAME, "/x"}, 0, 1'b1, 1'b1, 1'b0},
    '{1'b1, "/proc",                    0,    1'b1, 1'b0, 1'b0},
    '{1'b1, "task/x/fd",                0,    1'b1, 1'b0, 1'b0},
    '{1'b1, "1/fd/",                    40,   1'b0, 1'b0, 1'b0},
    '{1'b0, "/proc/self/cwd/",          40,   1'b0, 1'b0, 1'b0}
  };

  proc_magic_link_path_matcher #(
    .MAX_PATH(PATH_MAX)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .path_byte (path_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .escapes   (escapes),
    .is_virtual(is_virtual)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // verdict model: works on the whole path once its last beat is taken
  // ---------------------------------------------------------------------------

  // component p[lo..hi) spells exactly the given name
  function automatic bit seg_is(input char_t p[$], input int lo, input int hi,
                                input string name);
    if (hi - lo != name.len()) return 1'b0;
    for (int i = 0; i < name.len(); i++) begin
      if (p[lo+i] != char_t'(name[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // nonempty and decimal digits only
  function automatic bit seg_num(input char_t p[$], input int lo, input int hi);
    if (hi <= lo) return 1'b0;
    for (int i = lo; i < hi; i++) begin
      if (p[i] < 8'h30 || p[i] > 8'h39) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit seg_magic(input char_t p[$], input int lo, input int hi);
    for (int k = 0; k < 6; k++) begin
      if (seg_is(p, lo, hi, magic_names[k])) return 1'b1;
    end
    return 1'b0;
  endfunction

  // pid/ [task/tid/] magic, from a given start component; a magic name closed
  // by a slash settles the match, whatever follows
  function automatic bit walk_links(input char_t p[$], input int from,
                                    input link_walk_t start);
    link_walk_t st;
    int         lo;
    st = start;
    lo = from;
    for (int i = from; i < p.size() && st != WALK_HIT && st != WALK_MISS; i++) begin
      if (p[i] == SLASH) begin
        case (st)
          WALK_PID: begin
            st = (seg_num(p, lo, i) || seg_is(p, lo, i, "self") ||
                  seg_is(p, lo, i, "thread-self")) ? WALK_NAME : WALK_MISS;
          end
          WALK_NAME: begin
            if (seg_magic(p, lo, i)) st = WALK_HIT;
            else if (seg_is(p, lo, i, "task")) st = WALK_TID;
            else st = WALK_MISS;
          end
          WALK_TID: begin
            st = seg_num(p, lo, i) ? WALK_NAME2 : WALK_MISS;
          end
          default: begin
            st = seg_magic(p, lo, i) ? WALK_HIT : WALK_MISS;
          end
        endcase
        lo = i + 1;
      end
    end
    case (st)
      WALK_HIT:              return 1'b1;
      WALK_NAME, WALK_NAME2: return seg_magic(p, lo, p.size());
      default:               return 1'b0;
    endcase
  endfunction

  // whole first component equal to the prefix name
  function automatic bit under_prefix(input char_t p[$], input string name);
    int n;
    n = name.len();
    if (p.size() < n || !seg_is(p, 0, n, name)) return 1'b0;
    return p.size() == n || p[n] == SLASH;
  endfunction

  function automatic verdict_t classify_path(input char_t p[$], input bit rel);
    verdict_t v;
    int       len;
    bit       abs_hit;
    bit       rel_hit;
    bit       virt;
    len     = p.size() > PATH_MAX ? PATH_MAX : p.size();
    abs_hit = p.size() >= 6 && seg_is(p, 0, 6, "/proc/") && walk_links(p, 6, WALK_PID);
    virt    = under_prefix(p, "/proc") || under_prefix(p, "/sys") ||
              under_prefix(p, "/dev");
    // the prepended /proc/ only counts while the longer path still fits
    rel_hit = (len + 6 < PATH_MAX && walk_links(p, 0, WALK_PID)) ||
              walk_links(p, 0, WALK_NAME);
    v.esc  = rel ? rel_hit : abs_hit;
    v.virt = rel ? 1'b0 : (virt && !abs_hit);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // path builders
  // ---------------------------------------------------------------------------

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) gen_q.push_back(char_t'(s[i]));
  endfunction

  function automatic void add_digits(input int lo_n, input int hi_n);
    int n;
    n = $urandom_range(hi_n, lo_n);
    repeat (n) gen_q.push_back(8'h30 + char_t'($urandom_range(0, 9)));
  endfunction

  // slash-heavy junk, any nonzero byte
  function automatic void add_junk(input int lo_n, input int hi_n);
    int n;
    int pick;
    n = $urandom_range(hi_n, lo_n);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) gen_q.push_back(SLASH);
      else if (pick < 6) gen_q.push_back(8'h61 + char_t'($urandom_range(0, 25)));
      else gen_q.push_back(char_t'($urandom_range(1, 255)));
    end
  endfunction

  function automatic int pick_name();
    return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom_range(0, 15);
  endfunction

  function automatic void add_pid();
    case ($urandom_range(0, 5))
      0:       add_str("self");
      1:       add_str("thread-self");
      2, 3:    add_digits(1, 7);
      4:       add_str(name_pool[$urandom_range(0, 15)]);
      default: begin
        add_digits(0, 3);
        gen_q.push_back(8'h61 + char_t'($urandom_range(0, 25)));
      end
    endcase
  endfunction

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 6;
      default: return 30;
    endcase
  endfunction

  // mostly well-formed link paths with random content, some prefixes, some noise
  function automatic void build_path(input bit rel);
    int shape;
    int form;
    int cut;
    gen_q.delete();
    shape = $urandom_range(0, 99);
    if (shape < 65) begin
      // form: pid/... (0), task/<n>/... (1), bare name (2)
      form = $urandom_range(0, 2);
      if (!rel && $urandom_range(0, 9) != 0) begin
        add_str("/proc/");
        form = 0;
      end else if (rel && $urandom_range(0, 5) == 0) begin
        add_str("/proc/");
      end
      if (form == 0) begin
        add_pid();
        gen_q.push_back(SLASH);
      end
      if (form == 1 || (form == 0 && $urandom_range(0, 2) == 0)) begin
        add_str("task/");
        if ($urandom_range(0, 7) == 0) add_str(name_pool[$urandom_range(0, 15)]);
        else add_digits(1, 4);
        gen_q.push_back(SLASH);
      end
      add_str(name_pool[pick_name()]);
      if ($urandom_range(0, 2) == 0) begin
        gen_q.push_back(SLASH);
        add_junk(0, 6);
      end
    end else if (shape < 80) begin
      add_str(prefix_pool[$urandom_range(0, 5)]);
      case ($urandom_range(0, 2))
        0:       ;
        1:       begin
          gen_q.push_back(SLASH);
          add_junk(0, 8);
        end
        default: add_junk(1, 4);
      endcase
    end else begin
      add_junk(1, 24);
    end
    // damage a fifth of the paths: overwrite, cut short or insert
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: gen_q[$urandom_range(0, gen_q.size() - 1)] = char_t'($urandom_range(1, 255));
        1: begin
          cut = $urandom_range(1, gen_q.size());
          while (gen_q.size() > cut) void'(gen_q.pop_back());
        end
        default: gen_q.insert($urandom_range(0, gen_q.size() - 1),
                              char_t'($urandom_range(1, 255)));
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // bus side
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    end
  endfunction

  // send gen_q as one path; its verdict is queued once the last beat is taken
  task automatic send_path(input bit known, input verdict_t typed);
    char_t    taken[$];
    verdict_t v;
    int       gap;
    for (int i = 0; i < gen_q.size(); i++) begin
      if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 17);
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      path_byte <= gen_q[i];
      last      <= (i == gen_q.size() - 1);
      do @(posedge clk); while (!in_ready);
      taken.push_back(gen_q[i]);
    end
    v = known ? typed : classify_path(taken, rel_mode_shadow);
    path_verdicts.push_back(v);
  endtask

  // stop sending and let every verdict come back before touching the register
  task automatic drain_paths();
    in_valid <= 1'b0;
    while (path_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access phase; upper data bits are don't-care for the mode bit
  task automatic set_mode(input bit m);
    logic [31:0] noise;
    noise   = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_RELATIVE_MODE;
    pwdata  <= {noise[31:1], m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rel_mode_shadow = m;
  endtask

  // result side: check each verdict beat, then decide ready for the next edge
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (path_verdicts.size() == 0) begin
        note_mismatch("result beat with no path pending", 0, 1);
      end else begin
        want = path_verdicts.pop_front();
        if (escapes !== want.esc) note_mismatch("escapes", want.esc, escapes);
        if (is_virtual !== want.virt) note_mismatch("is_virtual", want.virt, is_virtual);
      end
    end
    // random stall bursts on the ready side
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    verdict_t typed;
    int       sent;
    int       goal;
    int       w;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, light idling on both sides
    in_gap_pct  = 10;
    out_gap_pct = 10;
    for (int r = 0; r < ROWS; r++) begin
      if (r == 0 || path_table[r].rel != rel_mode_shadow) begin
        drain_paths();
        set_mode(path_table[r].rel);
      end
      gen_q.delete();
      add_str(path_table[r].txt);
      repeat (path_table[r].pad) gen_q.push_back(8'h61);
      typed.esc  = path_table[r].known ? path_table[r].esc : 1'b0;
      typed.virt = path_table[r].known ? path_table[r].virt : 1'b0;
      send_path(path_table[r].known, typed);
    end

    // random rounds: mode flips each round, idling varies, last round runs flat out
    sent = 0;
    for (int rd = 0; rd < RANDOM_ROUNDS; rd++) begin
      drain_paths();
      set_mode(rd % 2 == 0);
      if (rd == RANDOM_ROUNDS - 1) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end else begin
        in_gap_pct  = pick_gap_pct();
        out_gap_pct = pick_gap_pct();
      end
      goal = sent + RANDOM_BYTES / RANDOM_ROUNDS;
      while (sent < goal) begin
        build_path(rel_mode_shadow);
        sent += gen_q.size();
        typed = '0;
        send_path(1'b0, typed);
      end
    end

    // wait out the last verdicts, then keep watching for strays
    in_valid <= 1'b0;
    for (w = 0; w < 50000 && path_verdicts.size() != 0; w++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (path_verdicts.size() != 0) begin
      note_mismatch("paths without a result", 0, path_verdicts.size());
    end
    if (mismatches == 0) begin
      $display("[proc_magic_link_path_matcher] OK");
    end else begin
      $display("[proc_magic_link_path_matcher] ERROR");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("[proc_magic_link_path_matcher] ERROR");
    $finish;
  end

endmodule
